>>> sv/fifo_kvs_pkg.sv
// shared types, constants and helpers for the fifo-replaced key/value store
// no dependencies; imported by every module of the block
package fifo_kvs_pkg;

    localparam int KEY_W   = 31;
    localparam int VALUE_W = 64;
    localparam int CTX_W   = 2;
    localparam int LEN_W   = 4;
    localparam int BYTES   = VALUE_W / 8;

    localparam int RING_SIZE_DEF     = 16;
    localparam int CONTEXT_COUNT_DEF = 4;

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // register map: one register, 4-byte stride
    localparam int              APB_AW        = 3;
    localparam logic            REG_VALUE_LEN = 1'b0;
    localparam logic [LEN_W-1:0] VALUE_LEN_RST = LEN_W'(8);

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

    // keep the low n bytes, zero the rest (n of eight or more keeps all)
    function automatic logic [VALUE_W-1:0] keep_bytes(input logic [VALUE_W-1:0] v,
                                                      input logic [LEN_W-1:0]   n);
        logic [VALUE_W-1:0] m;
        m = '0;
        for (int b = 0; b < BYTES; b++) begin
            if (LEN_W'(b) < n) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return v & m;
    endfunction

endpackage

>>> sv/fifo_kvs_slot_mem.sv
// slot memory: one key/value word per slot, one write and one read port
// depends on fifo_kvs_pkg for the slot word type
module fifo_kvs_slot_mem
    import fifo_kvs_pkg::*;
#(
    parameter int DEPTH = RING_SIZE_DEF * CONTEXT_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/fifo_kvs_cfg.sv
// apb register block holding value_len
// depends on fifo_kvs_pkg for the register map and reset value
module fifo_kvs_cfg
    import fifo_kvs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [LEN_W-1:0]  o_value_len
);

    logic [LEN_W-1:0] r_value_len;
    logic             w_sel_len;

    assign w_sel_len = (paddr[APB_AW-1] == REG_VALUE_LEN);

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_len <= VALUE_LEN_RST;
        end else if (psel && penable && pwrite && w_sel_len) begin
            r_value_len <= pwdata[LEN_W-1:0];
        end
    end

    // read back
    assign prdata      = w_sel_len ? {{(32-LEN_W){1'b0}}, r_value_len} : 32'd0;
    assign pready      = 1'b1;
    assign o_value_len = r_value_len;

endmodule

>>> sv/fifo_kvs_ctrl.sv
// search/update sequencer: ring pointers, valid bits, slot search and write-back
// depends on fifo_kvs_pkg; drives the ports of fifo_kvs_slot_mem
module fifo_kvs_ctrl
    import fifo_kvs_pkg::*;
#(
    parameter int RING_SIZE     = RING_SIZE_DEF,
    parameter int CONTEXT_COUNT = CONTEXT_COUNT_DEF,
    parameter int SLOT_AW       = $clog2(RING_SIZE * CONTEXT_COUNT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LEN_W-1:0]   i_value_len,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [CTX_W-1:0]   i_context_req,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_value_in,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [VALUE_W-1:0] o_value_out,
    // slot memory
    output logic               o_mem_wr_en,
    output logic [SLOT_AW-1:0] o_mem_wr_addr,
    output t_slot              o_mem_wr_data,
    output logic               o_mem_rd_en,
    output logic [SLOT_AW-1:0] o_mem_rd_addr,
    input  t_slot              i_mem_rd_data
);

    localparam int SLOTS  = RING_SIZE * CONTEXT_COUNT;
    localparam int IX_W   = $clog2(RING_SIZE);
    localparam int CNT_W  = $clog2(RING_SIZE + 1);
    localparam int CTX_AW = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [IX_W-1:0]  IX_LAST = IX_W'(RING_SIZE - 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(RING_SIZE);

    logic [1:0]         r_state, n_state;
    logic [SLOTS-1:0]   r_valid;
    logic [IX_W-1:0]    r_wp [CONTEXT_COUNT];

    // request held for the duration of the search
    logic               r_op;
    logic               r_in_range;
    logic [CTX_AW-1:0]  r_ctx;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic [SLOT_AW-1:0] r_base;

    // search walk and compare stage
    logic [IX_W-1:0]    r_ix;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pend;
    logic               r_pend_valid;
    logic [SLOT_AW-1:0] r_pend_addr;
    logic               r_hit;
    logic [SLOT_AW-1:0] r_hit_addr;
    logic [VALUE_W-1:0] r_hit_value;

    // output register
    logic               r_out_valid;
    logic               r_found;
    logic [VALUE_W-1:0] r_value_out;

    logic               w_accept;
    logic               w_range_ok;
    logic [CTX_AW-1:0]  w_ctx;
    logic [IX_W-1:0]    w_wp_in;
    logic [IX_W-1:0]    w_wp_cur;
    logic [IX_W-1:0]    w_ix_dec;
    logic               w_match;
    logic               w_miss_done;
    logic               w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_range_ok = (int'(i_context_req) < CONTEXT_COUNT);
    assign w_ctx      = CTX_AW'(i_context_req);
    assign w_wp_in    = r_wp[w_ctx];
    assign w_wp_cur   = r_wp[r_ctx];
    assign w_ix_dec   = (r_ix == '0) ? IX_LAST : r_ix - 1'b1;
    assign w_out_free = !r_out_valid || i_out_ready;

    // compare the slot read last cycle against the requested key
    assign w_match     = r_pend && r_pend_valid && (i_mem_rd_data.key == r_key);
    assign w_miss_done = !r_pend && (r_cnt == CNT_END);

    // memory read: walk the ring newest to oldest
    assign o_mem_rd_en   = (r_state == ST_SEARCH) && (r_cnt != CNT_END);
    assign o_mem_rd_addr = r_base + SLOT_AW'(r_ix);

    // memory write-back: the matching slot, else the oldest slot
    assign o_mem_wr_en   = (r_state == ST_FINISH) && w_out_free && r_in_range
                           && (r_op == OP_INSERT);
    assign o_mem_wr_addr = r_hit ? r_hit_addr : r_base + SLOT_AW'(w_wp_cur);
    assign o_mem_wr_data = '{key: r_key, value: r_value};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_range_ok ? ST_SEARCH : ST_FINISH;
                end
            end
            ST_SEARCH: begin
                if (w_match || w_miss_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CONTEXT_COUNT; c++) begin
                r_wp[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            // result valid: set when finishing, cleared once taken
            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op       <= i_opcode;
                        r_in_range <= w_range_ok;
                        r_ctx      <= w_ctx;
                        r_key      <= i_key;
                        r_value    <= keep_bytes(i_value_in, i_value_len);
                        r_base     <= SLOT_AW'(int'(i_context_req) * RING_SIZE);
                        r_ix       <= (w_wp_in == '0) ? IX_LAST : w_wp_in - 1'b1;
                        r_cnt      <= '0;
                        r_pend     <= 1'b0;
                        r_hit      <= 1'b0;
                    end
                end
                ST_SEARCH: begin
                    r_pend       <= o_mem_rd_en;
                    r_pend_addr  <= o_mem_rd_addr;
                    r_pend_valid <= r_valid[o_mem_rd_addr];
                    if (o_mem_rd_en) begin
                        r_ix  <= w_ix_dec;
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_match) begin
                        r_hit       <= 1'b1;
                        r_hit_addr  <= r_pend_addr;
                        r_hit_value <= i_mem_rd_data.value;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_found     <= r_hit;
                        r_value_out <= (r_hit && r_op == OP_LOOKUP) ? r_hit_value : '0;
                    end
                    if (o_mem_wr_en) begin
                        r_valid[o_mem_wr_addr] <= 1'b1;
                        if (!r_hit) begin
                            r_wp[r_ctx] <= (w_wp_cur == IX_LAST) ? '0 : w_wp_cur + 1'b1;
                        end
                    end
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_value_out = r_value_out;

endmodule

>>> sv/fifo_replaced_key_value_store_unit.sv
// fifo-replaced key/value store: per-context rings of slots in one synchronous memory
// search: accept, then one slot read per cycle newest to oldest, each compared in the cycle
//   after its read; a hit ends the walk early, a miss reads every slot of the ring, and a
//   context at or past CONTEXT_COUNT skips the walk and finds nothing
// throughput: one request at a time; the next is accepted only after the result is
//   registered, and the walk is paced by the single memory read port, one slot per cycle
// reset (synchronous, active low) clears valid bits, ring pointers and sets value_len to 8
module fifo_replaced_key_value_store_unit
    import fifo_kvs_pkg::*;
#(
    parameter int RING_SIZE     = RING_SIZE_DEF,
    parameter int CONTEXT_COUNT = CONTEXT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [CTX_W-1:0]   i_context_req,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_value_in,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [VALUE_W-1:0] o_value_out
);

    localparam int SLOTS   = RING_SIZE * CONTEXT_COUNT;
    localparam int SLOT_AW = $clog2(SLOTS);

    logic [LEN_W-1:0]   w_value_len;
    logic               w_mem_wr_en;
    logic [SLOT_AW-1:0] w_mem_wr_addr;
    t_slot              w_mem_wr_data;
    logic               w_mem_rd_en;
    logic [SLOT_AW-1:0] w_mem_rd_addr;
    t_slot              w_mem_rd_data;

    // configuration registers
    fifo_kvs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_value_len (w_value_len)
    );

    // search and update sequencer
    fifo_kvs_ctrl #(
        .RING_SIZE     (RING_SIZE),
        .CONTEXT_COUNT (CONTEXT_COUNT),
        .SLOT_AW       (SLOT_AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_len   (w_value_len),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_context_req (i_context_req),
        .i_key         (i_key),
        .i_value_in    (i_value_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_mem_wr_en   (w_mem_wr_en),
        .o_mem_wr_addr (w_mem_wr_addr),
        .o_mem_wr_data (w_mem_wr_data),
        .o_mem_rd_en   (w_mem_rd_en),
        .o_mem_rd_addr (w_mem_rd_addr),
        .i_mem_rd_data (w_mem_rd_data)
    );

    // slot storage
    fifo_kvs_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (SLOT_AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data),
        .i_rd_en   (w_mem_rd_en),
        .i_rd_addr (w_mem_rd_addr),
        .o_rd_data (w_mem_rd_data)
    );

    // a nonzero value only comes with a hit
    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_value_out != '0) |-> o_found)
        else $error("value returned without a hit");

    // one request at a time: no accept in the cycle after an accept
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");

    // memory is never written while the ring is being searched
    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_rd_en |-> !w_mem_wr_en)
        else $error("slot write during search");

    // a value_len write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[APB_AW-1] == REG_VALUE_LEN)
        |=> w_value_len == $past(pwdata[LEN_W-1:0]))
        else $error("value_len write lost");

endmodule
